@@ rtl/ptc_pkg.sv @@
package ptc_pkg;

    localparam int TAP_W     = 6;
    localparam int TAP_COUNT = 64;
    // highest tap a move up may reach from below
    localparam logic [TAP_W-1:0] TAP_TOP =
        (TAP_COUNT - 1 < 63) ? TAP_W'(TAP_COUNT - 1) : TAP_W'(63);

    localparam int CFG_DW = 32;
    localparam int CFG_AW = 5;

    typedef enum logic [2:0] {
        REG_THRESHOLD   = 3'd0,
        REG_FIRST_DELAY = 3'd1,
        REG_NEXT_DELAY  = 3'd2,
        REG_LOWEST_TAP  = 3'd3,
        REG_HIGHEST_TAP = 3'd4,
        REG_INITIAL_TAP = 3'd5,
        REG_REG_ENABLE  = 3'd6,
        REG_PHASE_RISES = 3'd7
    } t_reg_idx;

    localparam logic [15:0]      RST_THRESHOLD   = 16'hFFFF;
    localparam logic [TAP_W-1:0] RST_LOWEST_TAP  = TAP_W'(0);
    localparam logic [TAP_W-1:0] RST_HIGHEST_TAP = TAP_W'(63);
    localparam logic [TAP_W-1:0] RST_INITIAL_TAP = TAP_W'(0);

    typedef struct packed {
        logic [15:0]      current_threshold;
        logic [31:0]      first_delay;
        logic [31:0]      next_delay;
        logic [TAP_W-1:0] lowest_tap;
        logic [TAP_W-1:0] highest_tap;
        logic [TAP_W-1:0] initial_tap;
        logic             regulating_enabled;
        logic             phase_rises_with_tap;
    } t_cfg;

    typedef struct packed {
        logic             over_threshold;
        logic             tapped_down;
        logic             tapped_up;
        logic [TAP_W-1:0] tap_position;
    } t_result;

endpackage

@@ rtl/ptc_cfg.sv @@
module ptc_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ptc_pkg::CFG_AW-1:0]   paddr,
    input  logic [ptc_pkg::CFG_DW-1:0]   pwdata,
    output logic [ptc_pkg::CFG_DW-1:0]   prdata,
    output logic                         pready,
    output ptc_pkg::t_cfg                o_cfg
);

    ptc_pkg::t_cfg    r_cfg;
    ptc_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_idx  = ptc_pkg::t_reg_idx'(paddr[ptc_pkg::CFG_AW-1:2]);
    assign w_wr   = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.current_threshold    <= ptc_pkg::RST_THRESHOLD;
            r_cfg.first_delay          <= '0;
            r_cfg.next_delay           <= '0;
            r_cfg.lowest_tap           <= ptc_pkg::RST_LOWEST_TAP;
            r_cfg.highest_tap          <= ptc_pkg::RST_HIGHEST_TAP;
            r_cfg.initial_tap          <= ptc_pkg::RST_INITIAL_TAP;
            r_cfg.regulating_enabled   <= 1'b0;
            r_cfg.phase_rises_with_tap <= 1'b1;
        end else if (w_wr) begin
            case (w_idx)
                ptc_pkg::REG_THRESHOLD:   r_cfg.current_threshold <= pwdata[15:0];
                ptc_pkg::REG_FIRST_DELAY: r_cfg.first_delay       <= pwdata[31:0];
                ptc_pkg::REG_NEXT_DELAY:  r_cfg.next_delay        <= pwdata[31:0];
                ptc_pkg::REG_LOWEST_TAP:
                    r_cfg.lowest_tap <= pwdata[ptc_pkg::TAP_W-1:0];
                ptc_pkg::REG_HIGHEST_TAP:
                    r_cfg.highest_tap <= pwdata[ptc_pkg::TAP_W-1:0];
                ptc_pkg::REG_INITIAL_TAP:
                    r_cfg.initial_tap <= pwdata[ptc_pkg::TAP_W-1:0];
                ptc_pkg::REG_REG_ENABLE:  r_cfg.regulating_enabled   <= pwdata[0];
                ptc_pkg::REG_PHASE_RISES: r_cfg.phase_rises_with_tap <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            ptc_pkg::REG_THRESHOLD:   prdata = 32'(r_cfg.current_threshold);
            ptc_pkg::REG_FIRST_DELAY: prdata = r_cfg.first_delay;
            ptc_pkg::REG_NEXT_DELAY:  prdata = r_cfg.next_delay;
            ptc_pkg::REG_LOWEST_TAP:  prdata = 32'(r_cfg.lowest_tap);
            ptc_pkg::REG_HIGHEST_TAP: prdata = 32'(r_cfg.highest_tap);
            ptc_pkg::REG_INITIAL_TAP: prdata = 32'(r_cfg.initial_tap);
            ptc_pkg::REG_REG_ENABLE:  prdata = 32'(r_cfg.regulating_enabled);
            ptc_pkg::REG_PHASE_RISES: prdata = 32'(r_cfg.phase_rises_with_tap);
            default:                  prdata = '0;
        endcase
    end

endmodule

@@ rtl/ptc_core.sv @@
module ptc_core #(
    parameter int TIME_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  logic [TIME_BITS-1:0] i_time_now,
    input  logic [15:0]          i_current_value,
    input  logic                 i_disabled,
    input  logic                 i_locked,
    input  logic                 i_breaker_closed,
    input  logic                 i_side1_power_greater,
    input  ptc_pkg::t_cfg        i_cfg,
    output ptc_pkg::t_result     o_result
);

    localparam int CMP_W = (TIME_BITS > 32) ? TIME_BITS : 32;
    localparam int TW    = ptc_pkg::TAP_W;

    logic [TW-1:0]        r_tap, n_tap;
    logic                 r_up_armed, n_up_armed;
    logic                 r_dn_armed, n_dn_armed;
    logic [TIME_BITS-1:0] r_up_time, n_up_time;
    logic [TIME_BITS-1:0] r_dn_time, n_dn_time;
    logic [TIME_BITS-1:0] r_move_time, n_move_time;
    logic [TW-1:0]        r_up_ref, n_up_ref;
    logic [TW-1:0]        r_dn_ref, n_dn_ref;
    logic                 r_latched, n_latched;

    logic                 w_active, w_above, w_room_up, w_room_dn;
    logic [CMP_W-1:0]     w_up_wait, w_dn_wait, w_mv_wait;
    logic [CMP_W-1:0]     w_first, w_next;
    logic                 w_up_first, w_up_next, w_dn_first, w_dn_next;
    logic                 w_do_up, w_do_dn, w_go_up;

    always_comb begin
        w_active  = !i_disabled && !i_locked && i_breaker_closed;
        w_above   = i_current_value >= i_cfg.current_threshold;
        w_room_up = (r_tap < i_cfg.highest_tap) && (r_tap < ptc_pkg::TAP_TOP);
        w_room_dn = r_tap > i_cfg.lowest_tap;

        // elapsed times wrap modulo the time width
        w_up_wait = CMP_W'(TIME_BITS'(i_time_now - r_up_time));
        w_dn_wait = CMP_W'(TIME_BITS'(i_time_now - r_dn_time));
        w_mv_wait = CMP_W'(TIME_BITS'(i_time_now - r_move_time));
        w_first   = CMP_W'(i_cfg.first_delay);
        w_next    = CMP_W'(i_cfg.next_delay);

        w_up_first = r_up_armed && (w_up_wait >= w_first) && w_room_up &&
                     i_cfg.regulating_enabled && (r_tap == r_up_ref);
        w_up_next  = r_up_armed && (w_mv_wait >= w_next) && w_room_up &&
                     i_cfg.regulating_enabled && (r_tap != r_up_ref);
        w_dn_first = r_dn_armed && (w_dn_wait >= w_first) && w_room_dn &&
                     i_cfg.regulating_enabled && (r_tap == r_dn_ref);
        w_dn_next  = r_dn_armed && (w_mv_wait >= w_next) && w_room_dn &&
                     i_cfg.regulating_enabled && (r_tap != r_dn_ref);

        w_do_up = w_active && (w_up_first || w_up_next);
        w_do_dn = w_active && (w_dn_first || w_dn_next);
        w_go_up = i_side1_power_greater != i_cfg.phase_rises_with_tap;

        n_up_armed  = r_up_armed;
        n_dn_armed  = r_dn_armed;
        n_up_time   = r_up_time;
        n_dn_time   = r_dn_time;
        n_up_ref    = r_up_ref;
        n_dn_ref    = r_dn_ref;
        n_latched   = r_latched;
        n_move_time = r_move_time;

        if (w_active && w_above && !r_latched) begin
            if (w_go_up) begin
                n_up_time  = i_time_now;
                n_up_armed = 1'b1;
                n_up_ref   = r_tap;
                n_dn_armed = 1'b0;
                n_dn_ref   = i_cfg.highest_tap;
            end else begin
                n_dn_time  = i_time_now;
                n_dn_armed = 1'b1;
                n_dn_ref   = r_tap;
                n_up_armed = 1'b0;
                n_up_ref   = i_cfg.lowest_tap;
            end
            n_latched = 1'b1;
        end

        // drop the arming once the current falls back
        if (w_active && !w_above && r_latched) begin
            n_up_armed = 1'b0;
            n_dn_armed = 1'b0;
            n_up_ref   = i_cfg.lowest_tap;
            n_dn_ref   = i_cfg.highest_tap;
            n_latched  = 1'b0;
        end

        n_tap = r_tap + TW'(w_do_up) - TW'(w_do_dn);
        if (w_do_up || w_do_dn) begin
            n_move_time = i_time_now;
        end

        o_result.tap_position   = n_tap;
        o_result.tapped_up      = w_do_up;
        o_result.tapped_down    = w_do_dn;
        o_result.over_threshold = n_latched;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap       <= ptc_pkg::RST_INITIAL_TAP;
            r_up_armed  <= 1'b0;
            r_dn_armed  <= 1'b0;
            r_up_time   <= '0;
            r_dn_time   <= '0;
            r_move_time <= '0;
            r_up_ref    <= ptc_pkg::RST_LOWEST_TAP;
            r_dn_ref    <= ptc_pkg::RST_HIGHEST_TAP;
            r_latched   <= 1'b0;
        end else if (i_fire) begin
            r_tap       <= n_tap;
            r_up_armed  <= n_up_armed;
            r_dn_armed  <= n_dn_armed;
            r_up_time   <= n_up_time;
            r_dn_time   <= n_dn_time;
            r_move_time <= n_move_time;
            r_up_ref    <= n_up_ref;
            r_dn_ref    <= n_dn_ref;
            r_latched   <= n_latched;
        end
    end

endmodule

@@ rtl/phase_tap_changer_controller.sv @@
// Tap changer controller for a phase-shifting transformer.
// Input stream: one transfer per evaluation instant carrying the time stamp,
// the measured current and the disable, lock, breaker and power-direction
// flags. Output stream: one transfer per input transfer with the tap
// position after the instant, the up and down move flags and the
// overcurrent latch, in input order.
// An input transfer loads the input register; when the output can advance, the
// state update and the result register load together from it, and the result
// register then offers the transfer. Throughput is one transfer per cycle while
// the receiver keeps i_m_tready high; the tap state loop closes around the
// compare and update logic in ptc_core.
// When the receiver stalls, the result register holds its transfer and the
// input register still takes one more; once both are full o_s_tready drops.
// A synchronous reset empties both registers, loads all configuration
// registers with their defaults and returns the tap to the default initial
// tap with nothing armed. Write configuration through the APB port only
// while no transfer is in flight.
module phase_tap_changer_controller #(
    parameter int TIME_BITS = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // time_now, current_value, disabled, locked, breaker_closed,
    // side1_power_greater, zero fill
    input  logic [((TIME_BITS+20+7)/8)*8-1:0]     i_s_tdata,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // tap_position, tapped_up, tapped_down, over_threshold, zero fill
    output logic [15:0]                           o_m_tdata,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [ptc_pkg::CFG_AW-1:0]            paddr,
    input  logic [ptc_pkg::CFG_DW-1:0]            pwdata,
    output logic [ptc_pkg::CFG_DW-1:0]            prdata,
    output logic                                  pready
);

    localparam int IN_W = ((TIME_BITS + 20 + 7) / 8) * 8;
    localparam int CUR_LO = TIME_BITS;
    localparam int FLG_LO = TIME_BITS + 16;

    ptc_pkg::t_cfg    w_cfg;
    ptc_pkg::t_result w_result;
    ptc_pkg::t_result r_out;
    logic [IN_W-1:0]  r_in;
    logic             r_in_valid, r_out_valid;
    logic             w_advance, w_fire, w_take;

    assign w_advance  = !r_out_valid || i_m_tready;
    assign w_fire     = r_in_valid && w_advance;
    assign o_s_tready = !r_in_valid || w_advance;
    assign w_take     = i_s_tvalid && o_s_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = 16'(r_out);

    ptc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    ptc_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_fire                (w_fire),
        .i_time_now            (r_in[TIME_BITS-1:0]),
        .i_current_value       (r_in[CUR_LO+15:CUR_LO]),
        .i_disabled            (r_in[FLG_LO]),
        .i_locked              (r_in[FLG_LO+1]),
        .i_breaker_closed      (r_in[FLG_LO+2]),
        .i_side1_power_greater (r_in[FLG_LO+3]),
        .i_cfg                 (w_cfg),
        .o_result              (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in <= i_s_tdata;
        end
        if (w_fire) begin
            r_out <= w_result;
        end
    end

endmodule
